// ===== hw/rtl/dcfp_pkg.sv =====
// dcfp_pkg: shared constants and the result record of the command frame parser
// no dependencies; used by every module of the parser

package dcfp_pkg;

  localparam logic [7:0] OpenMark  = 8'h3C;  // '<'
  localparam logic [7:0] CloseMark = 8'h3E;  // '>'
  localparam logic [7:0] SepMark   = 8'h2C;  // ','

  localparam int unsigned ByteW    = 8;
  localparam int unsigned FrameLen = 9;
  localparam int unsigned CntW     = 4;

  localparam logic [CntW-1:0] FrameLenCnt = CntW'(FrameLen);
  localparam logic [CntW-1:0] OverMark    = CntW'(FrameLen + 1);

  localparam int unsigned OutDataW = 72;

  typedef struct packed {
    logic        frame_ok;
    logic [7:0]  cmd_id;
    logic [7:0]  arg_one;
    logic [7:0]  arg_two;
    logic [15:0] led_word0;
    logic [15:0] led_word1;
    logic [15:0] led_word2;
  } result_t;

endpackage

// ===== hw/rtl/dcfp_in_reg.sv =====
// dcfp_in_reg: input register of the parser, holds one received byte
// depends on dcfp_pkg

module dcfp_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [dcfp_pkg::ByteW-1:0] s_axis_tdata_i,  // rx_byte
  input  logic                      take_i,
  output logic                      valid_o,
  output logic [dcfp_pkg::ByteW-1:0] byte_o
);

  logic                       valid_q, valid_d;
  logic [dcfp_pkg::ByteW-1:0] byte_q;

  // a held byte leaves in the same cycle a new one arrives
  assign s_axis_tready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_axis_tready_o) begin
      valid_d = s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      byte_q <= s_axis_tdata_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== hw/rtl/dcfp_frame.sv =====
// dcfp_frame: frame tracking, payload store and result unpacking
// depends on dcfp_pkg

module dcfp_frame (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [dcfp_pkg::ByteW-1:0] byte_i,
  output logic                       emit_o,
  output dcfp_pkg::result_t          res_o
);

  logic                        in_frame_q, in_frame_d;
  logic [dcfp_pkg::CntW-1:0]   byte_count_q, byte_count_d;
  logic [dcfp_pkg::ByteW-1:0]  store_q [dcfp_pkg::FrameLen];
  logic                        is_open, is_close, is_sep, store_en;

  assign is_open  = (byte_i == dcfp_pkg::OpenMark);
  assign is_close = (byte_i == dcfp_pkg::CloseMark);
  assign is_sep   = (byte_i == dcfp_pkg::SepMark);

  assign emit_o   = in_frame_q && is_close;
  assign store_en = step_i && in_frame_q && !is_close && !is_sep &&
                    (byte_count_q < dcfp_pkg::FrameLenCnt);

  always_comb begin
    in_frame_d   = in_frame_q;
    byte_count_d = byte_count_q;
    if (step_i) begin
      if (!in_frame_q) begin
        if (is_open) begin
          in_frame_d   = 1'b1;
          byte_count_d = '0;
        end
      end else if (is_close) begin
        in_frame_d = 1'b0;
      end else if (!is_sep) begin
        if (byte_count_q < dcfp_pkg::FrameLenCnt) begin
          byte_count_d = byte_count_q + 1'b1;
        end else begin
          // sticky overflow mark, frame will be rejected
          byte_count_d = dcfp_pkg::OverMark;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      byte_count_q <= '0;
    end else begin
      in_frame_q   <= in_frame_d;
      byte_count_q <= byte_count_d;
    end
  end

  for (genvar g = 0; g < dcfp_pkg::FrameLen; g++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (store_en && (byte_count_q == dcfp_pkg::CntW'(g))) begin
        store_q[g] <= byte_i;
      end
    end
  end

  always_comb begin
    res_o = '0;
    if (byte_count_q == dcfp_pkg::FrameLenCnt) begin
      res_o.frame_ok  = 1'b1;
      res_o.cmd_id    = store_q[0];
      res_o.arg_one   = store_q[1];
      res_o.arg_two   = store_q[2];
      res_o.led_word0 = {store_q[4], store_q[3]};
      res_o.led_word1 = {store_q[6], store_q[5]};
      res_o.led_word2 = {store_q[8], store_q[7]};
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= dcfp_pkg::OverMark)
    else $error("byte count beyond overflow mark");

  a_open_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !in_frame_q && is_open) |=> (in_frame_q && byte_count_q == '0))
    else $error("frame open did not clear the count");

  a_close_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && emit_o) |=> !in_frame_q)
    else $error("frame still open after close");

  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_frame_q && byte_count_q == dcfp_pkg::OverMark && !(step_i && is_close))
      |=> byte_count_q == dcfp_pkg::OverMark)
    else $error("overflow mark lost inside a frame");

endmodule

// ===== hw/rtl/dcfp_out_reg.sv =====
// dcfp_out_reg: result register driving the output stream
// depends on dcfp_pkg

module dcfp_out_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  dcfp_pkg::result_t             res_i,
  output logic                          ready_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // cmd_id, arg_one, arg_two, led_word0, led_word1, led_word2
  output logic [dcfp_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tuser_o  // frame_ok
);

  logic              valid_q, valid_d;
  dcfp_pkg::result_t res_q;

  assign ready_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tuser_o  = res_q.frame_ok;
  assign m_axis_tdata_o  = {res_q.led_word2, res_q.led_word1, res_q.led_word0,
                            res_q.arg_two, res_q.arg_one, res_q.cmd_id};

endmodule

// ===== hw/rtl/delimited_command_frame_parser_top.sv =====
// Delimited command frame parser: takes one received byte per transaction and
// emits one result per '<' ... '>' frame. A byte is taken every cycle unless the
// output is back-pressured; each byte is held in the input register, the state
// update and result unpacking happen between that register and the result
// register, so a result is valid on the output once its closing '>' has passed
// through both registers. Commas inside a frame are dropped, a frame is good only
// with exactly nine payload bytes (tuser high), and a rejected frame gives all
// data fields zero. Throughput stalls only under output back-pressure.
// depends on dcfp_pkg, dcfp_in_reg, dcfp_frame, dcfp_out_reg

module delimited_command_frame_parser_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [dcfp_pkg::ByteW-1:0]    s_axis_tdata_i,   // rx_byte
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // cmd_id, arg_one, arg_two, led_word0, led_word1, led_word2
  output logic [dcfp_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tuser_o    // frame_ok
);

  logic                       in_valid, out_ready, step, emit;
  logic [dcfp_pkg::ByteW-1:0] in_byte;
  dcfp_pkg::result_t          res;

  // a byte is processed only when the result register can take a result
  assign step = in_valid && out_ready;

  dcfp_in_reg u_in_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .take_i          (step),
    .valid_o         (in_valid),
    .byte_o          (in_byte)
  );

  dcfp_frame u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte),
    .emit_o (emit),
    .res_o  (res)
  );

  dcfp_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (step && emit),
    .res_i           (res),
    .ready_o         (out_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
